[src/i2a_pkg.sv]
// i2a_pkg: shared types, constants and the digit table of the integer to ascii formatter
// no dependencies; used by every file under src

package i2a_pkg;

   // operand and digit geometry
   localparam int BIN_WIDTH  = 32;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH  = 6;
   localparam int IDX_WIDTH  = 4;

   // mode codes
   localparam logic [1:0] MODE_SIGNED   = 2'd0;
   localparam logic [1:0] MODE_UNSIGNED = 2'd1;
   localparam logic [1:0] MODE_HEX      = 2'd2;

   // fixed characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // command into the converter
   typedef struct packed {
      logic                 start;
      logic                 hex;
      logic                 neg;
      logic [BIN_WIDTH-1:0] mag;
   } conv_cmd_type;

   // digits handed from converter to emitter
   typedef struct packed {
      logic                 done;
      logic                 hex;
      logic                 neg;
      logic [BCD_WIDTH-1:0] digits;
   } conv_out_type;

   // emitter sequencer states
   typedef enum logic [2:0] {
      EM_IDLE,
      EM_SIGN,
      EM_ZERO,
      EM_X,
      EM_SKIP,
      EM_DIGIT,
      EM_SPACE
   } emit_state_type;

   // ascii code of one hex or decimal digit, upper case
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      case (d)
         4'h0: c = 8'h30;
         4'h1: c = 8'h31;
         4'h2: c = 8'h32;
         4'h3: c = 8'h33;
         4'h4: c = 8'h34;
         4'h5: c = 8'h35;
         4'h6: c = 8'h36;
         4'h7: c = 8'h37;
         4'h8: c = 8'h38;
         4'h9: c = 8'h39;
         4'hA: c = 8'h41;
         4'hB: c = 8'h42;
         4'hC: c = 8'h43;
         4'hD: c = 8'h44;
         4'hE: c = 8'h45;
         default: c = 8'h46;
      endcase
      return c;
   endfunction

endpackage

[src/i2a_if.sv]
// i2a_req_if and i2a_rsp_if: valid/ready channels of the formatter
// depends on i2a_pkg for the operand width

interface i2a_req_if;
   logic                          valid;
   logic                          ready;
   logic [i2a_pkg::BIN_WIDTH-1:0] value;
   logic [1:0]                    mode;

   modport source (output valid, value, mode, input ready);
   modport sink   (input valid, value, mode, output ready);
endinterface

interface i2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, char_code, last, input ready);
   modport sink   (input valid, char_code, last, output ready);
endinterface

[src/i2a_conv.sv]
// i2a_conv: bit-serial binary to bcd converter (shift and add-3), hex passes straight
// depends on i2a_pkg

module i2a_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  i2a_pkg::conv_cmd_type cmd,
   output logic                  idle,
   output i2a_pkg::conv_out_type res
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [i2a_pkg::CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [i2a_pkg::BIN_WIDTH-1:0]     bin_ff, bin_in;
   logic [i2a_pkg::BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic                              hex_ff, hex_in;
   logic                              neg_ff, neg_in;
   logic [i2a_pkg::BCD_WIDTH-1:0]     adj;

   // add 3 to every bcd digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < i2a_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // load, shift one bit per cycle, flag completion
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      hex_in  = hex_ff;
      neg_in  = neg_ff;
      if (cmd.start) begin
         hex_in = cmd.hex;
         neg_in = cmd.neg;
         if (cmd.hex) begin
            bcd_in  = {{(i2a_pkg::BCD_WIDTH - i2a_pkg::BIN_WIDTH){1'b0}}, cmd.mag};
            done_in = 1'b1;
         end else begin
            bin_in  = cmd.mag;
            bcd_in  = '0;
            cnt_in  = i2a_pkg::CNT_WIDTH'(i2a_pkg::BIN_WIDTH);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         bcd_in = {adj[i2a_pkg::BCD_WIDTH-2:0], bin_ff[i2a_pkg::BIN_WIDTH-1]};
         bin_in = {bin_ff[i2a_pkg::BIN_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == i2a_pkg::CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      hex_ff <= hex_in;
      neg_ff <= neg_in;
   end

   assign idle       = !busy_ff && !done_ff;
   assign res.done   = done_ff;
   assign res.hex    = hex_ff;
   assign res.neg    = neg_ff;
   assign res.digits = bcd_ff;

endmodule

[src/i2a_emit.sv]
// i2a_emit: character sequencer, shifts digits out one nibble per cycle into an output register
// while that register is free or being taken; depends on i2a_pkg and i2a_rsp_if

module i2a_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  i2a_pkg::conv_out_type res,
   output logic                  idle,
   i2a_rsp_if.source             rsp_item
);

   i2a_pkg::emit_state_type          state_ff, state_in;
   logic [i2a_pkg::BCD_WIDTH-1:0]    digit_ff, digit_in;
   logic [i2a_pkg::IDX_WIDTH-1:0]    idx_ff, idx_in;
   logic                             out_valid_ff, out_valid_in;
   logic [7:0]                       char_ff, char_in;
   logic                             last_ff, last_in;
   logic                             load;
   logic [3:0]                       top_digit;
   logic                             final_digit;

   assign load        = !out_valid_ff || rsp_item.ready;
   assign top_digit   = digit_ff[i2a_pkg::BCD_WIDTH-1 -: 4];
   assign final_digit = (idx_ff == i2a_pkg::IDX_WIDTH'(i2a_pkg::NUM_DIGITS - 1));

   // next state, digit shifting and output register load
   always_comb begin
      state_in     = state_ff;
      digit_in     = digit_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_item.ready;
      case (state_ff)
         i2a_pkg::EM_IDLE: begin
            if (res.done) begin
               digit_in = res.digits;
               idx_in   = '0;
               if (res.hex) begin
                  state_in = i2a_pkg::EM_ZERO;
               end else if (res.neg) begin
                  state_in = i2a_pkg::EM_SIGN;
               end else begin
                  state_in = i2a_pkg::EM_SKIP;
               end
            end
         end
         i2a_pkg::EM_SIGN: begin
            if (load) begin
               char_in      = i2a_pkg::CHAR_MINUS;
               last_in      = 1'b0;
               out_valid_in = 1'b1;
               state_in     = i2a_pkg::EM_SKIP;
            end
         end
         i2a_pkg::EM_ZERO: begin
            if (load) begin
               char_in      = i2a_pkg::CHAR_ZERO;
               last_in      = 1'b0;
               out_valid_in = 1'b1;
               state_in     = i2a_pkg::EM_X;
            end
         end
         i2a_pkg::EM_X: begin
            if (load) begin
               char_in      = i2a_pkg::CHAR_X;
               last_in      = 1'b0;
               out_valid_in = 1'b1;
               state_in     = i2a_pkg::EM_SKIP;
            end
         end
         // drop leading zeros, keeping at least the final digit
         i2a_pkg::EM_SKIP: begin
            if (top_digit == 4'd0 && !final_digit) begin
               digit_in = {digit_ff[i2a_pkg::BCD_WIDTH-5:0], 4'd0};
               idx_in   = idx_ff + 1'b1;
            end else begin
               state_in = i2a_pkg::EM_DIGIT;
            end
         end
         i2a_pkg::EM_DIGIT: begin
            if (load) begin
               char_in      = i2a_pkg::digit_char(top_digit);
               last_in      = 1'b0;
               out_valid_in = 1'b1;
               digit_in     = {digit_ff[i2a_pkg::BCD_WIDTH-5:0], 4'd0};
               idx_in       = idx_ff + 1'b1;
               if (final_digit) begin
                  state_in = i2a_pkg::EM_SPACE;
               end
            end
         end
         i2a_pkg::EM_SPACE: begin
            if (load) begin
               char_in      = i2a_pkg::CHAR_SPACE;
               last_in      = 1'b1;
               out_valid_in = 1'b1;
               state_in     = i2a_pkg::EM_IDLE;
            end
         end
         default: begin
            state_in = i2a_pkg::EM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::EM_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      idx_ff   <= idx_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign idle               = (state_ff == i2a_pkg::EM_IDLE);
   assign rsp_item.valid     = out_valid_ff;
   assign rsp_item.char_code = char_ff;
   assign rsp_item.last      = last_ff;

endmodule

[src/integer_to_ascii_formatter.sv]
// integer_to_ascii_formatter: top level, decodes the mode and joins converter and emitter
// depends on i2a_pkg, i2a_if, i2a_conv and i2a_emit

// Each item is a 32-bit value and a mode (0 signed decimal, 1 unsigned decimal, 2 or 3 hex);
// the block answers with 2 to 12 character items, sign or "0x" prefix first, then the digits
// most significant first without leading zeros, then one space flagged as last. A decimal
// item passes through the one-bit-per-cycle bcd converter, a hex item goes straight through;
// the emitter then drops the leading zeros and sends each character to the output register.
// The next item is taken once the last character sits in the output register, while it
// still waits to be taken.

module integer_to_ascii_formatter (
   input  logic      clock,
   input  logic      reset,
   i2a_req_if.sink   req_item,
   i2a_rsp_if.source rsp_item
);

   i2a_pkg::conv_cmd_type cmd;
   i2a_pkg::conv_out_type conv_res;
   logic                  conv_idle;
   logic                  emit_idle;
   logic                  neg;

   // take an item only when both stages are free
   assign req_item.ready = conv_idle && emit_idle;

   // sign and magnitude decode
   assign neg       = (req_item.mode == i2a_pkg::MODE_SIGNED)
                      && req_item.value[i2a_pkg::BIN_WIDTH-1];
   assign cmd.start = req_item.valid && req_item.ready;
   assign cmd.hex   = req_item.mode[1];
   assign cmd.neg   = neg;
   assign cmd.mag   = neg ? (~req_item.value + 1'b1) : req_item.value;

   i2a_conv u_conv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .idle  (conv_idle),
      .res   (conv_res)
   );

   i2a_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .res      (conv_res),
      .idle     (emit_idle),
      .rsp_item (rsp_item)
   );

endmodule

[tb/tb.sv]
// tb: self-checking testbench for integer_to_ascii_formatter, checking words as ascii text
// depends on i2a_pkg, i2a_if and the formatter rtl under src

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // mode 3 decodes as hex on bit 1 alone
   localparam logic [1:0] MODE_HEX_ALIAS = 2'd3;
   localparam int         LONG_HOLD     = 300;
   localparam int         RANDOM_WORDS  = 77;
   localparam int         DRAIN_LIMIT   = 20000;
   localparam int         SETTLE_CYCLES = 64;
   localparam int         REPORT_LIMIT  = 10;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_rec_type;

   typedef struct {
      logic [31:0] word;
      logic [1:0]  mode;
      string       text;
   } text_row_type;

   logic clock;
   logic reset;

   i2a_req_if req_bus ();
   i2a_rsp_if rsp_bus ();

   integer_to_ascii_formatter dut (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_bus),
      .rsp_item (rsp_bus)
   );

   // characters still owed by the block, oldest first
   char_rec_type pending_chars[$];
   // literal text per driven word, empty where the predictor decides
   string        typed_text_q[$];

   int  fault_count;
   int  words_taken;
   int  chars_seen;
   int  mode_seen[4];
   int  burst_left;
   bit  hold_wanted;
   bit  hold_done;

   // directed words: extremes, every mode, zero and the most negative value
   text_row_type directed_rows[23] = '{
      '{32'h0000_0000, i2a_pkg::MODE_SIGNED,    "0 "},
      '{32'h0000_0000, i2a_pkg::MODE_UNSIGNED,  "0 "},
      '{32'h0000_0000, i2a_pkg::MODE_HEX,       "0x0 "},
      '{32'h0000_0000, MODE_HEX_ALIAS,          "0x0 "},
      '{32'hFFFF_FFFF, i2a_pkg::MODE_SIGNED,    "-1 "},
      '{32'hFFFF_FFFF, i2a_pkg::MODE_UNSIGNED,  "4294967295 "},
      '{32'hFFFF_FFFF, i2a_pkg::MODE_HEX,       "0xFFFFFFFF "},
      '{32'hFFFF_FFFF, MODE_HEX_ALIAS,          "0xFFFFFFFF "},
      '{32'h8000_0000, i2a_pkg::MODE_SIGNED,    "-2147483648 "},
      '{32'h8000_0000, i2a_pkg::MODE_UNSIGNED,  "2147483648 "},
      '{32'h8000_0000, i2a_pkg::MODE_HEX,       "0x80000000 "},
      '{32'h7FFF_FFFF, i2a_pkg::MODE_SIGNED,    "2147483647 "},
      '{32'h7FFF_FFFF, i2a_pkg::MODE_UNSIGNED,  "2147483647 "},
      '{32'h0000_0001, i2a_pkg::MODE_SIGNED,    "1 "},
      '{32'h0000_0009, i2a_pkg::MODE_UNSIGNED,  "9 "},
      '{32'h0000_000A, i2a_pkg::MODE_UNSIGNED,  "10 "},
      '{32'h0000_000F, i2a_pkg::MODE_HEX,       "0xF "},
      '{32'h0000_0010, MODE_HEX_ALIAS,          "0x10 "},
      '{32'd1000000000, i2a_pkg::MODE_UNSIGNED, "1000000000 "},
      '{32'hFFFF_FFF6, i2a_pkg::MODE_SIGNED,    "-10 "},
      '{32'd999999999, i2a_pkg::MODE_SIGNED,    ""},
      '{32'h8000_0001, i2a_pkg::MODE_SIGNED,    ""},
      '{32'h00C0_FFEE, i2a_pkg::MODE_HEX,       ""}
   };

   // clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // count a failure, detail only the first few
   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // queue a literal text, space last
   function automatic void push_text(input string text);
      char_rec_type rec;
      for (int i = 0; i < text.len(); i++) begin
         rec.code = text[i];
         rec.last = (i == text.len() - 1);
         pending_chars.push_back(rec);
      end
   endfunction

   // predicted text of one word: prefix, digits msb first, trailing space
   function automatic void predict_text(input logic [31:0] word, input logic [1:0] mode);
      logic [7:0]   digs[10];
      logic [31:0]  mag;
      logic [31:0]  radix;
      logic [3:0]   d;
      logic         as_hex;
      logic         minus;
      int           ndig;
      char_rec_type rec;
      as_hex = mode[1];
      minus  = (mode == i2a_pkg::MODE_SIGNED) && word[31];
      mag    = minus ? (32'd0 - word) : word;
      radix  = as_hex ? 32'd16 : 32'd10;
      ndig   = 0;
      // digits least significant first, zero leaves a single digit
      do begin
         d = 4'(mag % radix);
         digs[ndig] = (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h41 + 8'(d) - 8'd10);
         ndig++;
         mag = mag / radix;
      end while (mag != 0 && ndig < 10);
      rec.last = 1'b0;
      if (as_hex) begin
         rec.code = i2a_pkg::CHAR_ZERO;
         pending_chars.push_back(rec);
         rec.code = i2a_pkg::CHAR_X;
         pending_chars.push_back(rec);
      end else if (minus) begin
         rec.code = i2a_pkg::CHAR_MINUS;
         pending_chars.push_back(rec);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         rec.code = digs[i];
         pending_chars.push_back(rec);
      end
      rec.code = i2a_pkg::CHAR_SPACE;
      rec.last = 1'b1;
      pending_chars.push_back(rec);
   endfunction

   // random word biased towards digit-count boundaries and extremes
   function automatic logic [31:0] random_word();
      logic [31:0] p;
      int          k;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 99);
         2: begin
            p = 32'd1;
            k = $urandom_range(0, 9);
            for (int i = 0; i < k; i++)
               p = p * 32'd10;
            return p + 32'($urandom_range(0, 2)) - 32'd1;
         end
         3: return 32'd0 - 32'($urandom_range(1, 1000));
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // offer one word, in bursts with random gaps between them
   task automatic send_word(input logic [31:0] word, input logic [1:0] mode, input string text);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
      end
      burst_left--;
      typed_text_q.push_back(text);
      req_bus.valid <= 1'b1;
      req_bus.value <= word;
      req_bus.mode  <= mode;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // result checking and prediction on accepted items
   always @(posedge clock) begin : monitor
      char_rec_type want;
      string        text;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
               note_fault($sformatf("unexpected char 0x%02h last %0b",
                                    rsp_bus.char_code, rsp_bus.last));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_bus.char_code !== want.code || rsp_bus.last !== want.last)
                  note_fault($sformatf("char 0x%02h last %0b, expected 0x%02h last %0b",
                                       rsp_bus.char_code, rsp_bus.last,
                                       want.code, want.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            words_taken++;
            mode_seen[req_bus.mode]++;
            text = typed_text_q.pop_front();
            if (text.len() != 0)
               push_text(text);
            else
               predict_text(req_bus.value, req_bus.mode);
         end
      end
   end

   // receiver: free-running, random stalls, short blocks and one long hold-off
   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         case ($urandom_range(0, 2))
            0: repeat ($urandom_range(5, 40)) begin
               rsp_bus.ready <= 1'b1;
               @(posedge clock);
            end
            1: repeat ($urandom_range(5, 40)) begin
               rsp_bus.ready <= ($urandom_range(0, 2) != 0);
               @(posedge clock);
            end
            default: begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         endcase
      end
   end

   // reset, stimulus, drain and verdict
   initial begin : stimulus
      int wait_cycles;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.mode  <= i2a_pkg::MODE_SIGNED;
      fault_count = 0;
      words_taken = 0;
      chars_seen  = 0;
      burst_left  = 0;
      hold_wanted = 1'b0;
      hold_done   = 1'b0;
      foreach (mode_seen[i]) mode_seen[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].mode, directed_rows[i].text);

      // random words, receiver holds off once early on
      hold_wanted = 1'b1;
      for (int n = 0; n < RANDOM_WORDS; n++)
         send_word(random_word(), 2'($urandom_range(0, 3)), "");
      req_bus.valid <= 1'b0;
      // let the monitor queue the text of the last word first
      @(posedge clock);

      // drain outstanding characters
      wait_cycles = 0;
      while (pending_chars.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_chars.size() != 0)
         note_fault($sformatf("%0d chars never arrived", pending_chars.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d words formatted: %0d signed, %0d unsigned, %0d hex (%0d as mode 3)",
               words_taken, mode_seen[i2a_pkg::MODE_SIGNED],
               mode_seen[i2a_pkg::MODE_UNSIGNED],
               mode_seen[i2a_pkg::MODE_HEX] + mode_seen[MODE_HEX_ALIAS],
               mode_seen[MODE_HEX_ALIAS]);
      $display("%0d characters checked, receiver held off once for %0d cycles",
               chars_seen, LONG_HOLD);
      if (fault_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[sim.f]
src/i2a_pkg.sv
src/i2a_if.sv
src/i2a_conv.sv
src/i2a_emit.sv
src/integer_to_ascii_formatter.sv
tb/tb.sv
